FILE: src/rtppk_pkg.sv
// shared types, constants and byte codes of the rtp l24 audio packetizer
// no dependencies; compiled first
package rtppk_pkg;

    localparam int PKT_FRAMES_DEF   = 48;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [7:0] HDR_VERSION = 8'h80;
    localparam logic [7:0] HDR_PTYPE   = 8'd96;

    // register indexes of the configuration port
    localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [1:0] REG_INPUT_BYTES      = 2'd1;
    localparam logic [1:0] REG_SYNC_SOURCE_ID   = 2'd2;
    localparam logic [1:0] REG_TIMESTAMP_OFFSET = 2'd3;

    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;
    localparam logic [1:0] INPUT_BYTES_RST   = 2'd3;
    localparam logic [1:0] INPUT_BYTES_16    = 2'd2;

    localparam logic [0:0] OP_SAMPLE = 1'b0;
    localparam logic [0:0] OP_RESYNC = 1'b1;

    // byte positions within one sample's output (header then payload)
    localparam logic [3:0] BYTE_VERSION  = 4'd0;
    localparam logic [3:0] BYTE_PTYPE    = 4'd1;
    localparam logic [3:0] BYTE_SEQ_HI   = 4'd2;
    localparam logic [3:0] BYTE_SEQ_LO   = 4'd3;
    localparam logic [3:0] BYTE_TS_3     = 4'd4;
    localparam logic [3:0] BYTE_TS_2     = 4'd5;
    localparam logic [3:0] BYTE_TS_1     = 4'd6;
    localparam logic [3:0] BYTE_TS_0     = 4'd7;
    localparam logic [3:0] BYTE_SSRC_3   = 4'd8;
    localparam logic [3:0] BYTE_SSRC_2   = 4'd9;
    localparam logic [3:0] BYTE_SSRC_1   = 4'd10;
    localparam logic [3:0] BYTE_SSRC_0   = 4'd11;
    localparam logic [3:0] BYTE_SMP_HI   = 4'd12;
    localparam logic [3:0] BYTE_SMP_MID  = 4'd13;
    localparam logic [3:0] BYTE_SMP_LO   = 4'd14;

    // timestamp divider: floor(3 * ns / 62500) = floor((3 * ns >> 2) / 15625),
    // four 16-bit quotient digits, each by reciprocal multiplication
    localparam logic [13:0] DIGIT_DIV     = 14'd15625;
    localparam logic [30:0] DIGIT_RECIP   = 31'd1125899907;  // ceil(2^44 / 15625)
    localparam int          DIV_STEP_W    = 3;
    localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = 3'd7;  // two steps per digit

    // decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic        hdr;
        logic        last;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [23:0] smp;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] ns;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } div_stat_t;

endpackage

FILE: src/rtppk_if.sv
// valid/ready channel interfaces for sample items and stream bytes
// no dependencies
interface rtppk_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  op;
    logic signed [23:0] sample_value;
    logic [63:0] ptp_time_ns;

    modport source (output valid, output op, output sample_value, output ptp_time_ns,
                    input ready);
    modport sink   (input valid, input op, input sample_value, input ptp_time_ns,
                    output ready);
endinterface

interface rtppk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       item_end;

    modport source (output valid, output out_byte, output packet_end, output item_end,
                    input ready);
    modport sink   (input valid, input out_byte, input packet_end, input item_end,
                    output ready);
endinterface

FILE: src/rtppk_tsdiv.sv
// resync timestamp divider, one 16-bit quotient digit at a time by reciprocal multiply
// depends on rtppk_pkg
module rtppk_tsdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  rtppk_pkg::div_req_t  req,
    output rtppk_pkg::div_stat_t stat
);
    import rtppk_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [63:0]           dvd_reg;
    logic [13:0]           rem_reg;
    logic [15:0]           digit_reg;
    logic [31:0]           quot_reg;

    logic [65:0] triple_ns;
    logic [29:0] part;
    logic [59:0] prod;
    logic [29:0] back_prod;

    always_comb
    begin
        // 3 * ns as ns + 2 * ns
        triple_ns = {2'b00, req.ns} + {1'b0, req.ns, 1'b0};
        // running remainder over the next 16-bit digit, always below 15625 * 2^16
        part      = {rem_reg, dvd_reg[63:48]};
        prod      = 60'(part) * 60'(DIGIT_RECIP);
        back_prod = 30'(digit_reg) * 30'(DIGIT_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= triple_ns[65:2];
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!step_reg[0])
                digit_reg <= prod[59:44];
            else
            begin
                rem_reg  <= 14'(part - back_prod);
                quot_reg <= {quot_reg[15:0], digit_reg};
                dvd_reg  <= {dvd_reg[47:0], 16'h0000};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

FILE: src/rtppk_front.sv
// front end: accepts items, keeps packet state, queues samples with header data
// depends on rtppk_pkg and rtppk_if
module rtppk_front #(
    parameter int PKT_FRAMES   = rtppk_pkg::PKT_FRAMES_DEF,
    parameter int MAX_CHANNELS = rtppk_pkg::MAX_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rtppk_in_if.sink             sample_ch,
    input  logic [3:0]           channel_count,
    input  logic [1:0]           input_bytes,
    input  logic [31:0]          timestamp_offset,
    output rtppk_pkg::div_req_t  div_req,
    input  rtppk_pkg::div_stat_t div_stat,
    input  logic                 queue_full,
    output logic                 push,
    output rtppk_pkg::entry_t    entry
);
    import rtppk_pkg::*;

    localparam int POS_W = $clog2(PKT_FRAMES * MAX_CHANNELS + 1);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam logic [31:0] HALF_PACKET = 32'(PKT_FRAMES / 2);
    localparam logic [31:0] TS_STEP     = 32'(PKT_FRAMES);

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      seq_reg;
    logic [31:0]      ts_reg;
    logic             pend_reg;

    logic [CH_W-1:0]  act_ch;
    logic [POS_W-1:0] total;
    logic             last;
    logic             accept;
    logic [23:0]      smp24;

    always_comb
    begin
        if (channel_count == 4'd0)
            act_ch = CH_W'(1);
        else if (32'(channel_count) > 32'(MAX_CHANNELS))
            act_ch = CH_W'(MAX_CHANNELS);
        else
            act_ch = CH_W'(channel_count);
    end

    assign total = POS_W'(PKT_FRAMES * act_ch);
    assign last  = (({1'b0, pos_reg} + 1'b1) >= {1'b0, total});
    assign smp24 = (input_bytes == INPUT_BYTES_16) ?
                   {sample_ch.sample_value[15:0], 8'h00} : sample_ch.sample_value;

    // hold off while a resync is being divided or the queue is full
    assign sample_ch.ready = !pend_reg && !queue_full;
    assign accept = sample_ch.valid && sample_ch.ready;

    assign div_req.start = accept && (sample_ch.op == OP_RESYNC);
    assign div_req.ns    = sample_ch.ptp_time_ns;

    assign push       = accept && (sample_ch.op == OP_SAMPLE);
    assign entry.hdr  = (pos_reg == '0);
    assign entry.last = last;
    assign entry.seq  = seq_reg;
    assign entry.ts   = ts_reg;
    assign entry.smp  = smp24;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seq_reg  <= '0;
            ts_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (div_req.start)
                pend_reg <= 1'b1;
            else if (div_stat.done)
            begin
                pend_reg <= 1'b0;
                ts_reg   <= div_stat.quot + timestamp_offset - HALF_PACKET;
            end

            if (push)
            begin
                if (last)
                begin
                    pos_reg <= '0;
                    seq_reg <= seq_reg + 16'd1;
                    ts_reg  <= ts_reg + TS_STEP;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
        end
    end

endmodule

FILE: src/rtppk_queue.sv
// short fifo of queued samples between front and back
// depends on rtppk_pkg
module rtppk_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rtppk_pkg::entry_t wr_entry,
    input  logic              pop,
    output rtppk_pkg::entry_t head,
    output logic              full,
    output logic              empty
);
    import rtppk_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

FILE: src/rtppk_back.sv
// back end: serializes queued samples into header and payload bytes
// depends on rtppk_pkg and rtppk_if
module rtppk_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rtppk_pkg::entry_t head,
    input  logic              empty,
    input  logic [31:0]       sync_source_id,
    output logic              pop,
    rtppk_out_if.source       stream_ch
);
    import rtppk_pkg::*;

    logic       started_reg;
    logic [3:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       pend_reg;
    logic       iend_reg;

    logic [3:0] cur_idx;
    logic       emit;
    logic [7:0] sel_byte;
    logic       is_final;

    assign cur_idx  = started_reg ? idx_reg : (head.hdr ? BYTE_VERSION : BYTE_SMP_HI);
    assign emit     = !empty && (!valid_reg || stream_ch.ready);
    assign is_final = (cur_idx == BYTE_SMP_LO);
    assign pop      = emit && is_final;

    always_comb
    begin
        case (cur_idx)
            BYTE_VERSION: sel_byte = HDR_VERSION;
            BYTE_PTYPE:   sel_byte = HDR_PTYPE;
            BYTE_SEQ_HI:  sel_byte = head.seq[15:8];
            BYTE_SEQ_LO:  sel_byte = head.seq[7:0];
            BYTE_TS_3:    sel_byte = head.ts[31:24];
            BYTE_TS_2:    sel_byte = head.ts[23:16];
            BYTE_TS_1:    sel_byte = head.ts[15:8];
            BYTE_TS_0:    sel_byte = head.ts[7:0];
            BYTE_SSRC_3:  sel_byte = sync_source_id[31:24];
            BYTE_SSRC_2:  sel_byte = sync_source_id[23:16];
            BYTE_SSRC_1:  sel_byte = sync_source_id[15:8];
            BYTE_SSRC_0:  sel_byte = sync_source_id[7:0];
            BYTE_SMP_HI:  sel_byte = head.smp[23:16];
            BYTE_SMP_MID: sel_byte = head.smp[15:8];
            BYTE_SMP_LO:  sel_byte = head.smp[7:0];
            default:      sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            idx_reg     <= BYTE_VERSION;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                valid_reg <= 1'b1;
                if (is_final)
                    started_reg <= 1'b0;
                else
                begin
                    started_reg <= 1'b1;
                    idx_reg     <= cur_idx + 4'd1;
                end
            end
            else if (stream_ch.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= sel_byte;
            pend_reg <= is_final && head.last;
            iend_reg <= is_final;
        end
    end

    assign stream_ch.valid      = valid_reg;
    assign stream_ch.out_byte   = byte_reg;
    assign stream_ch.packet_end = pend_reg;
    assign stream_ch.item_end   = iend_reg;

endmodule

FILE: src/aes67_rtp_audio_packetizer_core.sv
// rtp l24 audio packetizer: samples in, rtp packet bytes out, one byte per cycle while output ready
// path: an accepted sample is queued, then its bytes are loaded into the output register
// bytes: 3 per sample, 15 for the first sample of a packet; new samples queue while bytes go out
// resync: input held after a resync while the 8-step timestamp divider runs
// reset: rst_n clears sequence, timestamp, position, queue and output; config to defaults
// depends on rtppk_pkg, rtppk_if and the rtppk_front/tsdiv/queue/back modules
module aes67_rtp_audio_packetizer_core #(
    parameter int PKT_FRAMES   = rtppk_pkg::PKT_FRAMES_DEF,
    parameter int MAX_CHANNELS = rtppk_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rtppk_in_if.sink    sample_ch,
    rtppk_out_if.source stream_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rtppk_pkg::*;

    // configuration registers: the user must write them only while idle; the block does not enforce it
    logic [3:0]  channel_count_reg;
    logic [1:0]  input_bytes_reg;
    logic [31:0] sync_source_id_reg;
    logic [31:0] timestamp_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg    <= CHANNEL_COUNT_RST;
            input_bytes_reg      <= INPUT_BYTES_RST;
            sync_source_id_reg   <= '0;
            timestamp_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:    channel_count_reg    <= cfg_data[3:0];
                REG_INPUT_BYTES:      input_bytes_reg      <= cfg_data[1:0];
                REG_SYNC_SOURCE_ID:   sync_source_id_reg   <= cfg_data;
                REG_TIMESTAMP_OFFSET: timestamp_offset_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    div_req_t  div_req;
    div_stat_t div_stat;
    entry_t    wr_entry;
    entry_t    head;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    // front: takes items, tracks packet position, snapshots header fields per sample
    rtppk_front #(
        .PKT_FRAMES   (PKT_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_ch        (sample_ch),
        .channel_count    (channel_count_reg),
        .input_bytes      (input_bytes_reg),
        .timestamp_offset (timestamp_offset_reg),
        .div_req          (div_req),
        .div_stat         (div_stat),
        .queue_full       (full),
        .push             (push),
        .entry            (wr_entry)
    );

    // resync divider, shared by every resync item
    rtppk_tsdiv u_tsdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // short queue so front and back stall independently
    rtppk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // back: walks header and sample bytes into the output register
    rtppk_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .sync_source_id (sync_source_id_reg),
        .pop            (pop),
        .stream_ch      (stream_ch)
    );

    // a sample is never pushed into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("sample pushed into full queue");

    // a resync item blocks the input until its timestamp is computed
    a_resync_holds: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (!sample_ch.ready && div_stat.busy))
        else $error("input not held during resync");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    // a packet ends only on the final byte of a sample
    a_pkt_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        (stream_ch.valid && stream_ch.packet_end) |-> stream_ch.item_end)
        else $error("packet end off a sample boundary");

endmodule

FILE: sim/aes67_rtp_audio_packetizer_core_tb.sv
// testbench of the rtp l24 audio packetizer: random and directed sample items,
// byte stream checked against a local packetizer model with its own state
// depends on rtppk_pkg, rtppk_if and aes67_rtp_audio_packetizer_core
`timescale 1ns / 100ps

module aes67_rtp_audio_packetizer_core_tb;
    import rtppk_pkg::*;

    // packet geometry of the block as instantiated (default parameters)
    localparam int PKT_LEN_FRAMES = PKT_FRAMES_DEF;
    localparam int CHANNEL_LIMIT  = MAX_CHANNELS_DEF;
    // media clock: 48 kHz ticks from ptp ns, 3 ticks per 62500 ns
    localparam logic [63:0] NS_PER_TICK_GROUP = 64'd62500;
    localparam logic [63:0] TICKS_PER_GROUP   = 64'd3;

    localparam int IDLE_PCT       = 38;
    localparam int HOLDOFF_CYCLES = 300;
    // covers the timestamp divider after a resync that causes no bytes
    localparam int SETTLE_CYCLES  = 100;
    localparam int QUIET_LIMIT    = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [0:0]  op;
        logic [23:0] value;
        logic [63:0] ns;
    } pcm_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       item_end;
    } stream_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    rtppk_in_if  sample_ch();
    rtppk_out_if stream_ch();

    aes67_rtp_audio_packetizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .stream_ch (stream_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the configuration registers
    logic [3:0]  ch_setting;
    logic [1:0]  width_setting;
    logic [31:0] ssrc_setting;
    logic [31:0] ts_offset_setting;

    // model state: rtp sequence number, media timestamp, samples sent in packet
    logic [15:0] seq_num;
    logic [31:0] media_ts;
    logic [8:0]  pkt_pos;

    pcm_item_t    pcm_backlog[$];      // items waiting to be offered
    stream_byte_t expected_stream[$];  // bytes the block still owes us
    pcm_item_t    offered;             // item currently on the input channel

    logic steady;                      // no idling on either side while set
    int   holdoff_left;
    bit   holdoff_done;
    int   quiet_cycles;
    int   mismatches;
    int   bytes_seen;
    int   packets_seen;
    int   samples_sent;
    int   resyncs_sent;
    stream_byte_t got;
    stream_byte_t want;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // model of the packetizer: queues the bytes one input item causes
    task automatic packetize(input pcm_item_t it);
        logic [7:0]  bytes_out [0:14];
        logic [23:0] s24;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] ticks;
        stream_byte_t sb;
        int chans;
        int total;
        int n;
        bit closes;
        if (it.op == OP_RESYNC)
        begin
            // exact floor(ns * 3 / 62500) without overflowing the product
            q = it.ns / NS_PER_TICK_GROUP;
            r = it.ns % NS_PER_TICK_GROUP;
            ticks = q * TICKS_PER_GROUP + (r * TICKS_PER_GROUP) / NS_PER_TICK_GROUP;
            media_ts = ticks[31:0] + ts_offset_setting - 32'(PKT_LEN_FRAMES / 2);
            return;
        end
        chans = int'(ch_setting);
        if (chans == 0)
            chans = 1;
        if (chans > CHANNEL_LIMIT)
            chans = CHANNEL_LIMIT;
        total = PKT_LEN_FRAMES * chans;
        // 16-bit input takes the low half and widens it; any other width is 24-bit
        if (width_setting == INPUT_BYTES_16)
            s24 = {it.value[15:0], 8'h00};
        else
            s24 = it.value;
        n = 0;
        if (pkt_pos == 0)
        begin
            bytes_out[0]  = HDR_VERSION;
            bytes_out[1]  = HDR_PTYPE;
            bytes_out[2]  = seq_num[15:8];
            bytes_out[3]  = seq_num[7:0];
            bytes_out[4]  = media_ts[31:24];
            bytes_out[5]  = media_ts[23:16];
            bytes_out[6]  = media_ts[15:8];
            bytes_out[7]  = media_ts[7:0];
            bytes_out[8]  = ssrc_setting[31:24];
            bytes_out[9]  = ssrc_setting[23:16];
            bytes_out[10] = ssrc_setting[15:8];
            bytes_out[11] = ssrc_setting[7:0];
            n = 12;
        end
        bytes_out[n]     = s24[23:16];
        bytes_out[n + 1] = s24[15:8];
        bytes_out[n + 2] = s24[7:0];
        n = n + 3;
        // a shrunken packet length ends the packet on the current sample
        closes = (int'(pkt_pos) + 1 >= total);
        for (int i = 0; i < n; i++)
        begin
            sb.data     = bytes_out[i];
            sb.pkt_end  = closes && (i == n - 1);
            sb.item_end = (i == n - 1);
            expected_stream.insert(expected_stream.size(), sb);
        end
        if (closes)
        begin
            pkt_pos  = '0;
            seq_num  = seq_num + 16'd1;
            media_ts = media_ts + 32'(PKT_LEN_FRAMES);
        end
        else
        begin
            pkt_pos = pkt_pos + 9'd1;
        end
    endtask

    // one register write; the shadow follows at once since the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CHANNEL_COUNT:    ch_setting        = val[3:0];
            REG_INPUT_BYTES:      width_setting     = val[1:0];
            REG_SYNC_SOURCE_ID:   ssrc_setting      = val;
            REG_TIMESTAMP_OFFSET: ts_offset_setting = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [3:0] chans, input logic [1:0] width,
                                 input logic [31:0] ssrc, input logic [31:0] offset);
        write_reg(REG_CHANNEL_COUNT, {28'd0, chans});
        write_reg(REG_INPUT_BYTES, {30'd0, width});
        write_reg(REG_SYNC_SOURCE_ID, ssrc);
        write_reg(REG_TIMESTAMP_OFFSET, offset);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(input logic [0:0] op, input logic [23:0] value,
                              input logic [63:0] ns);
        pcm_item_t it;
        it.op    = op;
        it.value = value;
        it.ns    = ns;
        pcm_backlog.insert(pcm_backlog.size(), it);
    endtask

    // random items: mostly samples, a few resyncs, extremes now and then
    task automatic queue_random(input int count, input int resync_pct);
        pcm_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.op = ($urandom_range(99) < resync_pct) ? OP_RESYNC : OP_SAMPLE;
            case ($urandom_range(7))
                0:       it.value = 24'h7FFFFF;
                1:       it.value = 24'h800000;
                2:       it.value = 24'hFFFFFF;
                default: it.value = 24'($urandom);
            endcase
            if ($urandom_range(1) == 1)
                it.ns = {$urandom, $urandom};
            else
                it.ns = 64'($urandom_range(2000000));
            pcm_backlog.insert(pcm_backlog.size(), it);
        end
    endtask

    // sender pause: nothing offered until every owed byte came back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pcm_backlog.size() != 0 || sample_ch.valid || expected_stream.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input bit owed, input stream_byte_t exp_b,
                                 input stream_byte_t act_b);
        if (mismatches < REPORT_LIMIT)
        begin
            if (owed)
                $display("byte %0d: expected %02h pkt_end %b item_end %b, got %02h %b %b",
                         bytes_seen, exp_b.data, exp_b.pkt_end, exp_b.item_end,
                         act_b.data, act_b.pkt_end, act_b.item_end);
            else
                $display("byte %0d: unexpected %02h pkt_end %b item_end %b",
                         bytes_seen, act_b.data, act_b.pkt_end, act_b.item_end);
        end
        mismatches++;
    endtask

    // driver: offers items from the backlog, predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                packetize(offered);
                if (offered.op == OP_RESYNC)
                    resyncs_sent++;
                else
                    samples_sent++;
            end
            // a held item stays put until taken
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pcm_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    offered = pcm_backlog.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.op           <= offered.op;
                    sample_ch.sample_value <= offered.value;
                    sample_ch.ptp_time_ns  <= offered.ns;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every byte against the oldest owed byte, stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stream_ch.ready <= 1'b0;
        end
        else
        begin
            if (stream_ch.valid && stream_ch.ready)
            begin
                got = '{stream_ch.out_byte, stream_ch.packet_end, stream_ch.item_end};
                if (expected_stream.size() == 0)
                begin
                    flag_mismatch(1'b0, got, got);
                end
                else
                begin
                    want = expected_stream.pop_front();
                    if (got !== want)
                        flag_mismatch(1'b1, want, got);
                end
                bytes_seen++;
                if (got.pkt_end)
                    packets_seen++;
            end
            // one long hold-off while the sender still has plenty to offer,
            // so the internal queue fills and the input side backs up
            if (!holdoff_done && bytes_seen >= 150 && pcm_backlog.size() > 20)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                stream_ch.ready <= 1'b0;
            end
            else
            begin
                stream_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
                   || (stream_ch.valid && stream_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_CHANNEL_COUNT;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.op           = OP_SAMPLE;
        sample_ch.sample_value = '0;
        sample_ch.ptp_time_ns  = '0;
        stream_ch.ready        = 1'b0;
        offered                = '0;
        steady                 = 1'b0;
        holdoff_left           = 0;
        holdoff_done           = 1'b0;
        quiet_cycles           = 0;
        mismatches             = 0;
        bytes_seen             = 0;
        packets_seen           = 0;
        samples_sent           = 0;
        resyncs_sent           = 0;
        // reset values of registers and state
        ch_setting        = CHANNEL_COUNT_RST;
        width_setting     = INPUT_BYTES_RST;
        ssrc_setting      = '0;
        ts_offset_setting = '0;
        seq_num           = '0;
        media_ts          = '0;
        pkt_pos           = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: one channel, 24-bit, all-ones ssrc, largest positive offset
        load_settings(4'd1, 2'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_item(OP_SAMPLE, 24'h7FFFFF, 64'd0);   // header with seq 0, timestamp 0
        queue_item(OP_SAMPLE, 24'h800000, 64'd0);
        queue_item(OP_SAMPLE, 24'hFFFFFF, 64'd0);
        queue_item(OP_SAMPLE, 24'h000000, 64'd0);
        // resyncs mid-packet only show up in the next header
        queue_item(OP_RESYNC, 24'h000000, 64'd0);
        queue_item(OP_RESYNC, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(OP_RESYNC, 24'h000000, 64'd20833); // just below one tick
        queue_item(OP_RESYNC, 24'h000000, 64'd20834); // just reaches one tick
        queue_item(OP_SAMPLE, 24'h5A5A5A, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // directed: channel count 0 acts as 1, 16-bit input, most negative offset
        load_settings(4'd0, INPUT_BYTES_16, 32'h0000_0000, 32'h8000_0000);
        queue_item(OP_SAMPLE, 24'h7F8000, 64'd0);   // upper byte must be dropped
        queue_item(OP_SAMPLE, 24'hFF7FFF, 64'd0);
        queue_item(OP_SAMPLE, 24'h00FFFF, 64'd0);
        queue_item(OP_RESYNC, 24'h000000, 64'h8000_0000_0000_0000);
        queue_item(OP_SAMPLE, 24'h000001, 64'd0);
        queue_item(OP_SAMPLE, 24'h123456, 64'd0);
        wait_drained();

        // two channels at reset widths; the long receiver hold-off lands here
        load_settings(CHANNEL_COUNT_RST, INPUT_BYTES_RST, $urandom, $urandom);
        queue_random(90, 6);
        wait_drained();

        // no idling on either side for a whole phase
        load_settings(4'd0, INPUT_BYTES_16, 32'h0000_0000, 32'h8000_0000);
        steady = 1'b1;
        queue_random(100, 5);
        wait_drained();
        steady = 1'b0;

        // channel count above the limit saturates; width 0 is treated as 24-bit
        load_settings(4'd15, 2'd0, $urandom, $urandom);
        queue_random(60, 4);
        wait_drained();

        // packet shrinks under a position past its end: next sample closes it
        load_settings(4'd1, 2'd1, $urandom, $urandom);
        queue_random(30, 6);
        wait_drained();

        load_settings(4'd8, 2'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_random(20, 10);
        wait_drained();

        // random settings with short packets so headers keep coming
        for (int p = 0; p < 3; p++)
        begin
            load_settings(4'($urandom_range(3, 1)), 2'($urandom_range(3)), $urandom, $urandom);
            queue_random(35, 6);
            wait_drained();
        end

        $display("sent %0d samples and %0d resyncs; got %0d bytes in %0d closed packets",
                 samples_sent, resyncs_sent, bytes_seen, packets_seen);
        $display("%0d mismatching bytes, %0d still owed", mismatches, expected_stream.size());
        if (mismatches == 0 && expected_stream.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
